>>> rtl/firlp_pkg.sv
// ----------------------------------------------------------------------------
// firlp_pkg: shared types and constants for the 100-tap low-pass FIR
// Sample and coefficient widths, the half-response coefficient ROM and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package firlp_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int COEF_BITS    = 18;
  localparam int FRAC_BITS    = COEF_BITS - 1;
  localparam int HALF_ROM     = 50;
  localparam int ROM_AW       = 6;
  localparam int TAPS_DEFAULT = 100;

  typedef struct packed {
    logic load;    // capture the accepted word and set up the read pointer
    logic issue;   // step the tap pipeline by one tap
    logic finish;  // store the sample, advance the slot, load the output
  } firlp_cmd_t;

  typedef struct packed {
    logic tap_last;  // the tap now being issued is the final one
    logic done;      // the accumulator holds the complete sum
    logic out_free;  // the output register can take a new word
  } firlp_sts_t;

  // Half of the symmetric impulse response, signed Q1.17.
  function automatic logic signed [COEF_BITS-1:0] coef_rom(input logic [ROM_AW-1:0] idx);
    logic signed [COEF_BITS-1:0] c;
    unique case (idx)
      6'd0:  c = COEF_BITS'(155);
      6'd1:  c = COEF_BITS'(159);
      6'd2:  c = COEF_BITS'(166);
      6'd3:  c = COEF_BITS'(177);
      6'd4:  c = COEF_BITS'(192);
      6'd5:  c = COEF_BITS'(211);
      6'd6:  c = COEF_BITS'(234);
      6'd7:  c = COEF_BITS'(261);
      6'd8:  c = COEF_BITS'(292);
      6'd9:  c = COEF_BITS'(326);
      6'd10: c = COEF_BITS'(365);
      6'd11: c = COEF_BITS'(407);
      6'd12: c = COEF_BITS'(454);
      6'd13: c = COEF_BITS'(503);
      6'd14: c = COEF_BITS'(556);
      6'd15: c = COEF_BITS'(613);
      6'd16: c = COEF_BITS'(672);
      6'd17: c = COEF_BITS'(735);
      6'd18: c = COEF_BITS'(800);
      6'd19: c = COEF_BITS'(868);
      6'd20: c = COEF_BITS'(938);
      6'd21: c = COEF_BITS'(1009);
      6'd22: c = COEF_BITS'(1083);
      6'd23: c = COEF_BITS'(1157);
      6'd24: c = COEF_BITS'(1233);
      6'd25: c = COEF_BITS'(1310);
      6'd26: c = COEF_BITS'(1387);
      6'd27: c = COEF_BITS'(1464);
      6'd28: c = COEF_BITS'(1541);
      6'd29: c = COEF_BITS'(1617);
      6'd30: c = COEF_BITS'(1692);
      6'd31: c = COEF_BITS'(1766);
      6'd32: c = COEF_BITS'(1838);
      6'd33: c = COEF_BITS'(1909);
      6'd34: c = COEF_BITS'(1977);
      6'd35: c = COEF_BITS'(2043);
      6'd36: c = COEF_BITS'(2105);
      6'd37: c = COEF_BITS'(2165);
      6'd38: c = COEF_BITS'(2221);
      6'd39: c = COEF_BITS'(2274);
      6'd40: c = COEF_BITS'(2322);
      6'd41: c = COEF_BITS'(2367);
      6'd42: c = COEF_BITS'(2407);
      6'd43: c = COEF_BITS'(2442);
      6'd44: c = COEF_BITS'(2473);
      6'd45: c = COEF_BITS'(2499);
      6'd46: c = COEF_BITS'(2519);
      6'd47: c = COEF_BITS'(2535);
      6'd48: c = COEF_BITS'(2546);
      6'd49: c = COEF_BITS'(2551);
      default: c = COEF_BITS'(2551);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/firlp_ctrl.sv
// ----------------------------------------------------------------------------
// firlp_ctrl: sequencer for the shared multiply-accumulate
// Accepts a word, steps the datapath through every tap, waits for the
// pipeline to drain and for room in the output register, then retires.
// ----------------------------------------------------------------------------
`default_nettype none

module firlp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  firlp_pkg::firlp_sts_t sts_i,
  output firlp_pkg::firlp_cmd_t cmd_o
);
  import firlp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd_o.issue = 1'b1;
        if (sts_i.tap_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts_i.done && sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.load, cmd_o.issue, cmd_o.finish}) <= 1)
    else $error("more than one datapath command in a cycle");
  a_load_then_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.issue)
    else $error("tap issue did not follow a load");
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> in_ready_o)
    else $error("not ready after retiring a word");
`endif

endmodule

`default_nettype wire

>>> rtl/firlp_dp.sv
// ----------------------------------------------------------------------------
// firlp_dp: delay line memory, coefficient lookup and MAC pipeline
// One tap per cycle: read stage, registered multiply, accumulate. The sum
// is rounded half up, shifted and saturated into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module firlp_dp #(
  parameter int TAPS = firlp_pkg::TAPS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  firlp_pkg::firlp_cmd_t               cmd_i,
  output firlp_pkg::firlp_sts_t               sts_o,
  input  logic signed [firlp_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                record_start_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [firlp_pkg::SAMPLE_BITS-1:0] filtered_o
);
  import firlp_pkg::*;

  localparam int HD   = TAPS - 1;
  localparam int AW   = (HD > 1) ? $clog2(HD) : 1;
  localparam int KW   = $clog2(TAPS);
  localparam int PW   = SAMPLE_BITS + COEF_BITS;
  localparam int ACCW = PW + KW;
  localparam logic signed [ACCW:0] QMAX = (ACCW+1)'(2**(SAMPLE_BITS-1) - 1);
  localparam logic signed [ACCW:0] QMIN = ~QMAX;
  localparam logic signed [ACCW:0] HALF = (ACCW+1)'(2**(FRAC_BITS-1));

  // Delay line storage; hvalid_q marks slots written since the last clear.
  logic signed [SAMPLE_BITS-1:0] mem [HD];
  logic [HD-1:0]                 hvalid_q;
  logic [AW-1:0]                 ws_q, ws_d, rd_addr_q, ws_base;
  logic [KW-1:0]                 tap_q, mirror;
  logic [7:0]                    j8;
  logic [ROM_AW-1:0]             rom_idx;

  logic signed [SAMPLE_BITS-1:0] x_q, rd_data_q, op;
  logic                          s1_valid_q, s1_first_q, s1_last_q, s1_vbit_q;
  logic signed [COEF_BITS-1:0]   s1_coef_q;
  logic                          p_valid_q, p_first_q, p_last_q;
  logic signed [PW-1:0]          prod_q;
  logic signed [ACCW-1:0]        acc_q;
  logic                          done_q;
  logic signed [ACCW:0]          rnd, qv;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_q;

  // Tap k uses the mirrored half-table entry, clamped to the last one.
  always_comb begin
    mirror  = KW'(TAPS - 1) - tap_q;
    j8      = (tap_q < mirror) ? 8'(tap_q) : 8'(mirror);
    rom_idx = (j8 >= 8'(HALF_ROM)) ? ROM_AW'(HALF_ROM - 1) : j8[ROM_AW-1:0];
  end

  assign ws_base = record_start_i ? '0 : ws_q;
  assign ws_d    = (ws_q == AW'(HD - 1)) ? '0 : ws_q + 1'b1;

  assign op  = s1_first_q ? x_q : (s1_vbit_q ? rd_data_q : '0);
  assign rnd = {acc_q[ACCW-1], acc_q} + HALF;
  assign qv  = rnd >>> FRAC_BITS;
  assign sat = (qv > QMAX) ? QMAX[SAMPLE_BITS-1:0] :
               (qv < QMIN) ? QMIN[SAMPLE_BITS-1:0] : qv[SAMPLE_BITS-1:0];

  assign sts_o.tap_last = (tap_q == KW'(TAPS - 1));
  assign sts_o.done     = done_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign filtered_o     = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      mem[ws_q] <= x_q;
    end
    rd_data_q <= mem[rd_addr_q];
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= sample_i;
    end
    if (cmd_i.issue) begin
      s1_first_q <= (tap_q == '0);
      s1_last_q  <= sts_o.tap_last;
      s1_coef_q  <= coef_rom(rom_idx);
      s1_vbit_q  <= hvalid_q[rd_addr_q];
    end
    if (s1_valid_q) begin
      prod_q    <= s1_coef_q * op;
      p_first_q <= s1_first_q;
      p_last_q  <= s1_last_q;
    end
    if (p_valid_q) begin
      acc_q <= p_first_q ? ACCW'(prod_q) : acc_q + ACCW'(prod_q);
    end
    if (cmd_i.finish) begin
      out_q <= sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvalid_q    <= '0;
      ws_q        <= '0;
      rd_addr_q   <= '0;
      tap_q       <= '0;
      s1_valid_q  <= 1'b0;
      p_valid_q   <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.issue;
      p_valid_q  <= s1_valid_q;
      if (cmd_i.load) begin
        tap_q     <= '0;
        rd_addr_q <= (ws_base == '0) ? AW'(HD - 1) : ws_base - 1'b1;
        if (record_start_i) begin
          hvalid_q <= '0;
          ws_q     <= '0;
        end
      end
      if (cmd_i.issue) begin
        tap_q <= tap_q + 1'b1;
        // The first tap uses the new sample, so the pointer holds once.
        if (tap_q != '0) begin
          rd_addr_q <= (rd_addr_q == '0) ? AW'(HD - 1) : rd_addr_q - 1'b1;
        end
      end
      if (p_valid_q && p_last_q) begin
        done_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        done_q         <= 1'b0;
        hvalid_q[ws_q] <= 1'b1;
        ws_q           <= ws_d;
        out_valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_finish_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> done_q && (!out_valid_q || out_ready_i))
    else $error("retire without a complete sum or a free output");
  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !done_q && !s1_valid_q && !p_valid_q)
    else $error("new word loaded while the MAC pipeline is busy");
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ws_q <= AW'(HD - 1) && rd_addr_q <= AW'(HD - 1))
    else $error("delay line pointer out of range");
`endif

endmodule

`default_nettype wire

>>> rtl/fir_lowpass_100_tap.sv
// A new word is accepted only after the one before it retires, set by the single shared
// multiply-accumulate that walks every tap once per word.
// Reset (rst_ni low, asynchronous) empties the delay line through per-slot valid
// flags, returns the write slot to zero and drops the output word; no sweep follows.
// ----------------------------------------------------------------------------
// fir_lowpass_100_tap: symmetric low-pass FIR on a sensor sample stream
// One filtered word per sample word; tuser bit 0 restarts the record from a
// zero history before that sample is used.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_lowpass_100_tap #(
  parameter int TAPS = firlp_pkg::TAPS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] sample
  input  logic [0:0]  s_axis_tuser_i,   // [0] record_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [15:0] filtered
);
  import firlp_pkg::*;

  firlp_cmd_t cmd;
  firlp_sts_t sts;
  logic signed [SAMPLE_BITS-1:0] filtered;

  firlp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  firlp_dp #(
    .TAPS (TAPS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sample_i       ($signed(s_axis_tdata_i[SAMPLE_BITS-1:0])),
    .record_start_i (s_axis_tuser_i[0]),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .filtered_o     (filtered)
  );

  assign m_axis_tdata_o = filtered;

endmodule

`default_nettype wire
